>>> hw/rtl/cv3_pkg.sv
// shared types and constants for the 3x3 convolution block
package cv3_pkg;

	// window geometry
	localparam int unsigned MASK_SIZE = 3;
	localparam int unsigned TAPS      = MASK_SIZE * MASK_SIZE;

	// pixel and arithmetic widths
	localparam int unsigned PIX_W  = 8;
	localparam int unsigned PROD_W = 17;
	localparam int unsigned ROW_W  = 18;
	localparam int unsigned SUM_W  = 20;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// configuration register widths and reset values
	localparam int unsigned IW_W       = 10;
	localparam int unsigned COEF_LO_W  = 48;
	localparam int unsigned COEF_HI_W  = 24;
	localparam int unsigned CFG_DATA_W = 48;
	localparam logic [IW_W-1:0]      IMAGE_WIDTH_RST = 10'd512;
	localparam logic [COEF_LO_W-1:0] COEF_LOW_RST    = 48'h0100FF0100FF;
	localparam logic [COEF_HI_W-1:0] COEF_HIGH_RST   = 24'h0100FF;

	// rows of history kept per image
	localparam logic [1:0] ROWS_FULL = 2'd2;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_COEF_LOW    = 2'd1,
		REG_COEF_HIGH   = 2'd2
	} cv3_reg_e;

	// nine window pixels and nine coefficients, entry k = row*3+col
	typedef logic [TAPS-1:0][PIX_W-1:0] cv3_win_t;
	typedef logic [TAPS-1:0][PIX_W-1:0] cv3_coef_t;

	// handshake between the line buffer stage and the multiply-add pipe
	typedef struct packed {
		logic valid;
		logic free;
	} cv3_hs_t;

endpackage

>>> hw/rtl/cv3_mac.sv
// nine-tap multiply, adder tree and clamp with output register
module cv3_mac import cv3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             win_valid,
	output cv3_hs_t          hs,
	input  cv3_win_t         win,
	input  cv3_coef_t        coef,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIX_W-1:0] pixel_out
);

	logic                                v_s2, v_s3, out_valid_q;
	logic [TAPS-1:0][PROD_W-1:0]         prod_s2;
	logic [MASK_SIZE-1:0][ROW_W-1:0]     row_s3;
	logic [PIX_W-1:0]                    pixel_q;
	logic                                free_o, free3, free2;
	logic [TAPS-1:0][PROD_W-1:0]         prod_c;
	logic [MASK_SIZE-1:0][ROW_W-1:0]     row_c;
	logic signed [SUM_W-1:0]             total_c;
	logic [PIX_W-1:0]                    clamp_c;

	// stage availability, back from the output register
	assign free_o = !out_valid_q || !out_stall;
	assign free3  = !v_s3 || free_o;
	assign free2  = !v_s2 || free3;

	assign hs.valid = v_s2;
	assign hs.free  = free2;

	// nine independent signed by unsigned products, both operands at product width
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod_c[k] = $signed({{(PROD_W-PIX_W){coef[k][PIX_W-1]}}, coef[k]})
				* $signed({{(PROD_W-PIX_W){1'b0}}, win[k]});
		end
	end

	// one sum per window row
	always_comb begin
		for (int m = 0; m < MASK_SIZE; m++) begin
			row_c[m] = ROW_W'($signed(prod_s2[m*MASK_SIZE]))
				+ ROW_W'($signed(prod_s2[m*MASK_SIZE+1]))
				+ ROW_W'($signed(prod_s2[m*MASK_SIZE+2]));
		end
	end

	// final sum and clamp to the pixel range
	always_comb begin
		total_c = SUM_W'($signed(row_s3[0])) + SUM_W'($signed(row_s3[1]))
			+ SUM_W'($signed(row_s3[2]));
		if (total_c < 0) begin
			clamp_c = '0;
		end else if (total_c > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
			clamp_c = PIX_MAX;
		end else begin
			clamp_c = total_c[PIX_W-1:0];
		end
	end

	// valid bits of the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free2) begin
				v_s2 <= win_valid;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (free2) begin
			prod_s2 <= prod_c;
		end
		if (free3) begin
			row_s3 <= row_c;
		end
		if (free_o) begin
			pixel_q <= clamp_c;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;

endmodule

>>> hw/rtl/convolve_3x3_clamp.sv
// top level of the streaming 3x3 convolution with clamp
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  in       | in_valid / in_stall  | pixel_in, frame_start
//  out      | out_valid / out_stall| pixel_out
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// one pixel per clock unless the output stalls; results pass stage one and the pipe
// the line buffer is one memory, read at acceptance, written as stage one passes on,
// with a forwarding path when that column is read back on the same edge (width of one)
// the multiply-add pipe has three stages: products, row sums, total with clamp
// reset clears counters, window taps and valid bits; the line buffer is never cleared
// an output stall only holds back input once all stages are occupied
module convolve_3x3_clamp import cv3_pkg::*; #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_out,
	input  logic                  cfg_write,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (CW > IW_W) ? CW : IW_W;
	localparam int LW   = 2 * PIX_W;

	// configuration registers
	logic [IW_W-1:0]      image_width_q;
	logic [COEF_LO_W-1:0] coef_low_q;
	logic [COEF_HI_W-1:0] coef_high_q;

	// position state
	logic [AW-1:0] col_q;
	logic [1:0]    rows_q;

	// line buffer and window taps
	logic [LW-1:0]                       line_mem [MAX_WIDTH];
	logic [2*MASK_SIZE-1:0][PIX_W-1:0]   taps_q;

	// stage one
	logic              v_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [AW-1:0]     col_s1;
	logic [1:0]        rows_s1;
	logic [LW-1:0]     rd_data_s1;
	logic              fwd_s1;
	logic [LW-1:0]     fwd_data_s1;

	logic              accept;
	logic              free1, move1;
	cv3_hs_t           mac_hs;
	logic [CMPW-1:0]   width_c;
	logic [AW-1:0]     col_in_c;
	logic [1:0]        rows_in_c;
	logic [AW-1:0]     col_eff_c;
	logic [1:0]        rows_eff_c;
	logic [CMPW-1:0]   col_next_c;
	logic [LW-1:0]     entry_c;
	logic [PIX_W-1:0]  up1_c, up2_c;
	logic [2*MASK_SIZE-1:0][PIX_W-1:0] taps_eff_c, taps_next_c;
	logic [LW-1:0]     wr_data_c;
	cv3_win_t          win_c;
	cv3_coef_t         coef_c;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			coef_low_q    <= COEF_LOW_RST;
			coef_high_q   <= COEF_HIGH_RST;
		end else if (cfg_write) begin
			case (cv3_reg_e'(cfg_index))
				REG_IMAGE_WIDTH: image_width_q <= cfg_data[IW_W-1:0];
				REG_COEF_LOW:    coef_low_q    <= cfg_data[COEF_LO_W-1:0];
				REG_COEF_HIGH:   coef_high_q   <= cfg_data[COEF_HI_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage one frees when it is empty or passes on
	assign free1    = !v_s1 || mac_hs.free;
	assign move1    = v_s1 && mac_hs.free;
	assign in_stall = !free1;
	assign accept   = in_valid && free1;

	// width in use, limited to one and the buffer length
	always_comb begin
		if (image_width_q == '0) begin
			width_c = CMPW'(1);
		end else if (CMPW'(image_width_q) > CMPW'(MAX_WIDTH)) begin
			width_c = CMPW'(MAX_WIDTH);
		end else begin
			width_c = CMPW'(image_width_q);
		end
	end

	// column and row bookkeeping for the incoming transaction
	always_comb begin
		col_in_c  = frame_start ? '0 : col_q;
		rows_in_c = frame_start ? '0 : rows_q;
		if (CMPW'(col_in_c) >= width_c) begin
			col_eff_c  = '0;
			rows_eff_c = (rows_in_c == ROWS_FULL) ? ROWS_FULL : rows_in_c + 2'd1;
		end else begin
			col_eff_c  = col_in_c;
			rows_eff_c = rows_in_c;
		end
		col_next_c = CMPW'(col_eff_c) + CMPW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= '0;
		end else if (accept) begin
			if (col_next_c >= width_c) begin
				col_q  <= '0;
				rows_q <= (rows_eff_c == ROWS_FULL) ? ROWS_FULL : rows_eff_c + 2'd1;
			end else begin
				col_q  <= col_next_c[AW-1:0];
				rows_q <= rows_eff_c;
			end
		end
	end

	// stage one valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free1) begin
			v_s1 <= accept;
		end
	end

	// stage one payload, with forwarding of the write that lands on this edge
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			col_s1      <= col_eff_c;
			rows_s1     <= rows_eff_c;
			fwd_s1      <= v_s1 && (col_s1 == col_eff_c);
			fwd_data_s1 <= wr_data_c;
		end
	end

	// line buffer read and write ports
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= line_mem[col_eff_c];
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			line_mem[col_s1] <= wr_data_c;
		end
	end

	// window assembly; taps are empty at the start of every row
	always_comb begin
		entry_c    = fwd_s1 ? fwd_data_s1 : rd_data_s1;
		up1_c      = (rows_s1 != 2'd0) ? entry_c[PIX_W-1:0] : '0;
		up2_c      = (rows_s1 == ROWS_FULL) ? entry_c[LW-1:PIX_W] : '0;
		taps_eff_c = (col_s1 == '0) ? '0 : taps_q;
		wr_data_c  = {up1_c, pix_s1};

		win_c[0] = pix_s1;
		win_c[1] = taps_eff_c[0];
		win_c[2] = taps_eff_c[1];
		win_c[3] = up1_c;
		win_c[4] = taps_eff_c[2];
		win_c[5] = taps_eff_c[3];
		win_c[6] = up2_c;
		win_c[7] = taps_eff_c[4];
		win_c[8] = taps_eff_c[5];

		taps_next_c[0] = pix_s1;
		taps_next_c[1] = taps_eff_c[0];
		taps_next_c[2] = up1_c;
		taps_next_c[3] = taps_eff_c[2];
		taps_next_c[4] = up2_c;
		taps_next_c[5] = taps_eff_c[4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (move1) begin
			taps_q <= taps_next_c;
		end
	end

	assign coef_c = cv3_coef_t'({coef_high_q, coef_low_q});

	// multiply-add pipe and output register
	cv3_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (v_s1),
		.hs        (mac_hs),
		.win       (win_c),
		.coef      (coef_c),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out)
	);

endmodule

>>> hw/rtl/cv3_checker.sv
// port-level checks for the 3x3 convolution block and their binding
module cv3_checker import cv3_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [PIX_W-1:0] pixel_out
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out))
		else $error("result changed while stalled");

	// an empty output register means the whole pipe can move
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output register empty");

	// an accepted transaction reaches the output while the output is not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind convolve_3x3_clamp cv3_checker u_cv3_checker (.*);
